@@ src/msrc_pkg.sv @@
// shared types, constants and crc function for the modbus reply checker
package msrc_pkg;

  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [15:0] TimeoutReset = 16'd1000;
  localparam logic        CmdReset     = 1'b1;
  localparam logic [7:0]  CountMax     = 8'hFF;
  localparam logic [15:0] TickMax      = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_BYTE   = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_REINIT = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_BUSY  = 2'd1,
    PH_DONE  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    OC_PENDING = 3'd0,
    OC_VALID   = 3'd1,
    OC_CRC     = 3'd2,
    OC_TIMEOUT = 3'd3,
    OC_UNUSUAL = 3'd4
  } outcome_e;

  typedef enum logic {
    CFG_TIMEOUT = 1'b0,
    CFG_COMMAND = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic        send_request;
    logic [1:0]  phase;
    logic [2:0]  outcome;
    logic [15:0] reading;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ src/msrc_core.sv @@
// reply checker state and single-pass next-state logic
module msrc_core import msrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [1:0]  func_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  input  logic [15:0] timeout_ticks_i,
  input  logic        command_kind_i,
  output result_t     result_o
);

  phase_e      phase_q, phase_d;
  outcome_e    outcome_q, outcome_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  older_q, older_d;
  logic [7:0]  newer_q, newer_d;
  logic [15:0] value_q, value_d;
  logic [15:0] tick_q, tick_d;
  outcome_e    oc;

  always_comb begin
    phase_d   = phase_q;
    outcome_d = outcome_q;
    crc_d     = crc_q;
    count_d   = count_q;
    older_d   = older_q;
    newer_d   = newer_q;
    value_d   = value_q;
    tick_d    = tick_q;
    result_o.send_request = 1'b0;
    unique case (func_e'(func_i))
      FUNC_START: begin
        if (phase_q == PH_READY) begin
          phase_d = PH_BUSY;
          crc_d   = CrcInit;
          count_d = '0;
          older_d = '0;
          newer_d = '0;
          tick_d  = '0;
          result_o.send_request = command_kind_i;
        end
      end
      FUNC_BYTE: begin
        if (phase_q == PH_BUSY) begin
          if (count_q >= 8'd2) begin
            crc_d = crc_feed(crc_q, older_q);
          end
          if (command_kind_i) begin
            if (count_q == 8'd3) begin
              value_d = {rx_byte_i, value_q[7:0]};
            end else if (count_q == 8'd4) begin
              value_d = {value_q[15:8], rx_byte_i};
            end
          end
          if (frame_end_i) begin
            if (count_q < 8'd4) begin
              outcome_d = OC_CRC;
            end else if ({rx_byte_i, newer_q} != crc_d) begin
              outcome_d = OC_CRC;
            end else if (command_kind_i) begin
              outcome_d = (value_d <= 16'd1) ? OC_VALID : OC_UNUSUAL;
            end
            phase_d = PH_DONE;
          end
          older_d = newer_q;
          newer_d = rx_byte_i;
          if (count_q != CountMax) begin
            count_d = count_q + 8'd1;
          end
        end
      end
      FUNC_TICK: begin
        if (phase_q == PH_BUSY) begin
          if (tick_q != TickMax) begin
            tick_d = tick_q + 16'd1;
          end
          if (tick_d >= timeout_ticks_i) begin
            outcome_d = OC_TIMEOUT;
            phase_d   = PH_DONE;
          end
        end
      end
      FUNC_REINIT: begin
        phase_d   = PH_READY;
        outcome_d = OC_TIMEOUT;
      end
      default: ;
    endcase
    oc = (phase_d == PH_DONE) ? outcome_d : OC_PENDING;
    result_o.phase   = phase_d;
    result_o.outcome = oc;
    result_o.reading = (oc == OC_VALID || oc == OC_UNUSUAL) ? value_d : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_READY;
      outcome_q <= OC_TIMEOUT;
      crc_q     <= CrcInit;
      count_q   <= '0;
      older_q   <= '0;
      newer_q   <= '0;
      value_q   <= '0;
      tick_q    <= '0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      outcome_q <= outcome_d;
      crc_q     <= crc_d;
      count_q   <= count_d;
      older_q   <= older_d;
      newer_q   <= newer_d;
      value_q   <= value_d;
      tick_q    <= tick_d;
    end
  end

endmodule

@@ src/msrc_out_reg.sv @@
// result register with valid/stall handshake toward the receiver
module msrc_out_reg import msrc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t result_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q;
  result_t data_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= result_i;
    end
  end

endmodule

@@ src/modbus_sensor_reply_checker_unit.sv @@
// top level of the modbus rtu reply checker
//
// input channel: in_valid_i / in_stall_o carry one item (func, rx_byte,
// frame_end); each item yields exactly one result item on the output
// channel out_valid_o / out_stall_i (send_request, phase, outcome, reading).
// an accepted item is held in an input register, evaluated in one pass
// against the checker state and captured in the result register once
// that register can take it. throughput is one item per cycle unless the
// receiver stalls; the crc update is one byte per pass.
// when the receiver stalls, the result register holds, the input register
// holds its item and in_stall_o rises once both are occupied.
// reset clears both registers, puts the checker in ready with outcome
// timeout and crc 0xffff, and loads timeout_ticks 1000 and command_kind 1.
// configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect on
// the next edge; the user, not the block, must ensure no item is in flight.
module modbus_sensor_reply_checker_unit import msrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_request_o,
  output logic [1:0]  phase_o,
  output logic [2:0]  outcome_o,
  output logic [15:0] reading_o
);

  logic [15:0] timeout_q;
  logic        command_q;
  logic        in_valid_q;
  logic [1:0]  func_q;
  logic [7:0]  byte_q;
  logic        end_q;
  logic        advance;
  logic        take;
  result_t     core_res;
  result_t     out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      command_q <= CmdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_COMMAND: command_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign take       = !in_valid_q || advance;
  assign in_stall_o = !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_valid_i) begin
      func_q <= func_i;
      byte_q <= rx_byte_i;
      end_q  <= frame_end_i;
    end
  end

  msrc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (in_valid_q && advance),
    .func_i         (func_q),
    .rx_byte_i      (byte_q),
    .frame_end_i    (end_q),
    .timeout_ticks_i(timeout_q),
    .command_kind_i (command_q),
    .result_o       (core_res)
  );

  msrc_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_q),
    .result_i   (core_res),
    .ready_o    (advance),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (out_res)
  );

  assign send_request_o = out_res.send_request;
  assign phase_o        = out_res.phase;
  assign outcome_o      = out_res.outcome;
  assign reading_o      = out_res.reading;

endmodule
